### hdl/ftc_pkg.sv
// Shared types and constants for the forest tree counter.
// No dependencies; used by the core and its testbench.
package ftc_pkg;

  localparam int unsigned FieldW   = 10;
  localparam logic [9:0]  CountMax = 10'h3FF;

  localparam logic ModeEdge = 1'b0;
  localparam logic ModeEval = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INS_A,
    ST_INS_RB,
    ST_INS_B,
    ST_SEEK,
    ST_SEEK_CHK,
    ST_ROW,
    ST_SCAN,
    ST_VIS,
    ST_POP,
    ST_POP_WAIT
  } ftc_state_e;

endpackage

### hdl/ftc_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module ftc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/forest_tree_counter_core.sv
// Forest tree counter: adjacency matrix, visited marks and walk stack in RAMs.
// Depends on ftc_pkg and ftc_ram.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  command  | start_i, busy_o             | mode_i, vertex_a_i, vertex_b_i
//  result   | result_valid_o (one cycle)  | tree_count_o
//  config   | cfg_valid_i, cfg_ready_o    | cfg_data_i (vertex_count)
//
// An edge command does a read-modify-write of two matrix rows, row a then row b.
// Evaluate scans the matrix one bit per cycle while bits are clear (a set bit
// adds a visited-mark read; each vertex adds row and stack reads).
// After the result, and after reset, a clearing pass over all MAX_VERTICES rows
// zeroes matrix rows and visited marks; busy_o stays high meanwhile.
// The result cannot be stalled; config writes are always taken.
module forest_tree_counter_core #(
  parameter int unsigned MAX_VERTICES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       mode_i,
  input  logic [9:0] vertex_a_i,
  input  logic [9:0] vertex_b_i,
  output logic       result_valid_o,
  output logic [9:0] tree_count_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW = (NW > ftc_pkg::FieldW) ? NW : ftc_pkg::FieldW;
  localparam int unsigned SW = AW + NW;

  ftc_pkg::ftc_state_e state_q, state_d;

  logic [9:0]              vcount_q;
  logic [NW-1:0]           n_q, n_d;
  logic [NW-1:0]           s_q, s_d;
  logic [NW-1:0]           i_q, i_d;
  logic [AW-1:0]           v_q, v_d;
  logic [AW-1:0]           p_q, p_d;
  logic                    has_par_q, has_par_d;
  logic [AW-1:0]           sp_q, sp_d;
  logic [AW-1:0]           c_q, c_d;
  logic [AW-1:0]           a_q, a_d;
  logic [AW-1:0]           b_q, b_d;
  logic                    cyc_q, cyc_d;
  logic [9:0]              trees_q, trees_d;
  logic                    res_q, res_d;
  logic [MAX_VERTICES-1:0] row_q, row_d;

  logic                    row_we, row_re;
  logic [AW-1:0]           row_waddr, row_raddr;
  logic [MAX_VERTICES-1:0] row_wdata, row_rdata;
  logic                    vis_we, vis_re, vis_wdata, vis_rdata;
  logic [AW-1:0]           vis_waddr, vis_raddr;
  logic                    stk_we, stk_re;
  logic [AW-1:0]           stk_waddr, stk_raddr;
  logic [SW-1:0]           stk_wdata, stk_rdata;

  logic                    accept;
  logic                    ends_ok;
  logic [EW-1:0]           a_ext, b_ext, vc_ext;
  logic [AW-1:0]           i_idx;

  assign accept       = start_i & ~busy_o;
  assign busy_o       = (state_q != ftc_pkg::ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign result_valid_o = res_q;
  assign tree_count_o = trees_q;

  assign a_ext   = EW'(vertex_a_i);
  assign b_ext   = EW'(vertex_b_i);
  assign vc_ext  = EW'(vcount_q);
  assign ends_ok = (vertex_a_i != '0) && (a_ext <= EW'(MAX_VERTICES)) &&
                   (vertex_b_i != '0) && (b_ext <= EW'(MAX_VERTICES));
  assign i_idx   = i_q[AW-1:0];

  ftc_ram #(.Width(MAX_VERTICES), .Depth(MAX_VERTICES)) u_adj (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  ftc_ram #(.Width(1), .Depth(MAX_VERTICES)) u_vis (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (vis_re),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  ftc_ram #(.Width(SW), .Depth(MAX_VERTICES)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftc_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode_i == ftc_pkg::ModeEval) begin
            state_d = ftc_pkg::ST_SEEK;
          end else if (ends_ok) begin
            state_d = ftc_pkg::ST_INS_A;
          end
        end
      end
      ftc_pkg::ST_CLEAR: begin
        if (c_q == AW'(MAX_VERTICES - 1)) state_d = ftc_pkg::ST_IDLE;
      end
      ftc_pkg::ST_INS_A:  state_d = ftc_pkg::ST_INS_RB;
      ftc_pkg::ST_INS_RB: state_d = ftc_pkg::ST_INS_B;
      ftc_pkg::ST_INS_B:  state_d = ftc_pkg::ST_IDLE;
      ftc_pkg::ST_SEEK: begin
        state_d = (s_q == n_q) ? ftc_pkg::ST_CLEAR : ftc_pkg::ST_SEEK_CHK;
      end
      ftc_pkg::ST_SEEK_CHK: begin
        state_d = vis_rdata ? ftc_pkg::ST_SEEK : ftc_pkg::ST_ROW;
      end
      ftc_pkg::ST_ROW: state_d = ftc_pkg::ST_SCAN;
      ftc_pkg::ST_SCAN: begin
        if (i_q == n_q) begin
          state_d = ftc_pkg::ST_POP;
        end else if (row_q[i_idx]) begin
          state_d = ftc_pkg::ST_VIS;
        end
      end
      ftc_pkg::ST_VIS: begin
        state_d = vis_rdata ? ftc_pkg::ST_SCAN : ftc_pkg::ST_ROW;
      end
      ftc_pkg::ST_POP: begin
        state_d = (sp_q == '0) ? ftc_pkg::ST_SEEK : ftc_pkg::ST_POP_WAIT;
      end
      ftc_pkg::ST_POP_WAIT: state_d = ftc_pkg::ST_ROW;
      default: state_d = ftc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    n_d       = n_q;
    s_d       = s_q;
    i_d       = i_q;
    v_d       = v_q;
    p_d       = p_q;
    has_par_d = has_par_q;
    sp_d      = sp_q;
    c_d       = c_q;
    a_d       = a_q;
    b_d       = b_q;
    cyc_d     = cyc_q;
    trees_d   = trees_q;
    res_d     = 1'b0;
    row_d     = row_q;
    row_we    = 1'b0;
    row_waddr = v_q;
    row_wdata = row_q;
    row_re    = 1'b0;
    row_raddr = v_q;
    vis_we    = 1'b0;
    vis_waddr = s_q[AW-1:0];
    vis_wdata = 1'b1;
    vis_re    = 1'b0;
    vis_raddr = s_q[AW-1:0];
    stk_we    = 1'b0;
    stk_waddr = sp_q;
    stk_wdata = {v_q, i_q + NW'(1)};
    stk_re    = 1'b0;
    stk_raddr = sp_q - AW'(1);

    unique case (state_q)
      ftc_pkg::ST_IDLE: begin
        if (accept) begin
          a_d       = AW'(vertex_a_i - 10'd1);
          b_d       = AW'(vertex_b_i - 10'd1);
          row_re    = (mode_i == ftc_pkg::ModeEdge);
          row_raddr = AW'(vertex_a_i - 10'd1);
          trees_d   = (mode_i == ftc_pkg::ModeEval) ? '0 : trees_q;
          s_d       = '0;
          n_d       = (vc_ext >= EW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_q);
        end
      end
      ftc_pkg::ST_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = c_q;
        row_wdata = '0;
        vis_we    = 1'b1;
        vis_waddr = c_q;
        vis_wdata = 1'b0;
        c_d       = c_q + AW'(1);
      end
      ftc_pkg::ST_INS_A: begin
        row_we         = 1'b1;
        row_waddr      = a_q;
        row_wdata      = row_rdata;
        row_wdata[b_q] = 1'b1;
      end
      ftc_pkg::ST_INS_RB: begin
        row_re    = 1'b1;
        row_raddr = b_q;
      end
      ftc_pkg::ST_INS_B: begin
        row_we         = 1'b1;
        row_waddr      = b_q;
        row_wdata      = row_rdata;
        row_wdata[a_q] = 1'b1;
      end
      ftc_pkg::ST_SEEK: begin
        if (s_q == n_q) begin
          res_d = 1'b1;
          c_d   = '0;
        end else begin
          vis_re = 1'b1;
        end
      end
      ftc_pkg::ST_SEEK_CHK: begin
        if (vis_rdata) begin
          s_d = s_q + NW'(1);
        end else begin
          // open a new walk from this root
          vis_we    = 1'b1;
          v_d       = s_q[AW-1:0];
          i_d       = '0;
          sp_d      = '0;
          cyc_d     = 1'b0;
          has_par_d = 1'b0;
          row_re    = 1'b1;
          row_raddr = s_q[AW-1:0];
        end
      end
      ftc_pkg::ST_ROW: begin
        row_d = row_rdata;
        // drop the tree edge back to the parent
        if (has_par_q) row_d[p_q] = 1'b0;
      end
      ftc_pkg::ST_SCAN: begin
        if (i_q != n_q) begin
          if (row_q[i_idx]) begin
            vis_re    = 1'b1;
            vis_raddr = i_idx;
          end else begin
            i_d = i_q + NW'(1);
          end
        end
      end
      ftc_pkg::ST_VIS: begin
        if (vis_rdata) begin
          cyc_d = 1'b1;
          i_d   = i_q + NW'(1);
        end else begin
          // descend: delete edge, mark, push current frame
          row_we           = 1'b1;
          row_waddr        = v_q;
          row_wdata        = row_q;
          row_wdata[i_idx] = 1'b0;
          vis_we           = 1'b1;
          vis_waddr        = i_idx;
          stk_we           = 1'b1;
          sp_d             = sp_q + AW'(1);
          p_d              = v_q;
          has_par_d        = 1'b1;
          v_d              = i_idx;
          i_d              = '0;
          row_re           = 1'b1;
          row_raddr        = i_idx;
        end
      end
      ftc_pkg::ST_POP: begin
        if (sp_q == '0) begin
          if (!cyc_q && trees_q != ftc_pkg::CountMax) trees_d = trees_q + 10'd1;
          s_d = s_q + NW'(1);
        end else begin
          stk_re = 1'b1;
          sp_d   = sp_q - AW'(1);
        end
      end
      ftc_pkg::ST_POP_WAIT: begin
        v_d       = stk_rdata[SW-1:NW];
        i_d       = stk_rdata[NW-1:0];
        has_par_d = 1'b0;
        row_re    = 1'b1;
        row_raddr = stk_rdata[SW-1:NW];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ftc_pkg::ST_CLEAR;
      vcount_q  <= 10'd1;
      c_q       <= '0;
      trees_q   <= '0;
      cyc_q     <= 1'b0;
      res_q     <= 1'b0;
      has_par_q <= 1'b0;
      sp_q      <= '0;
      s_q       <= '0;
      i_q       <= '0;
      n_q       <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_valid_i && cfg_ready_o) vcount_q <= cfg_data_i;
      c_q       <= c_d;
      trees_q   <= trees_d;
      cyc_q     <= cyc_d;
      res_q     <= res_d;
      has_par_q <= has_par_d;
      sp_q      <= sp_d;
      s_q       <= s_d;
      i_q       <= i_d;
      n_q       <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    p_q   <= p_d;
    a_q   <= a_d;
    b_q   <= b_d;
    row_q <= row_d;
  end

endmodule

### test/forest_tree_counter_core_tb.sv
// Testbench for forest_tree_counter_core: loads random and directed graphs edge by edge,
// evaluates them, and checks each tree count against a built-in depth-first predictor.
// Depends on ftc_pkg and the forest_tree_counter_core RTL.
module forest_tree_counter_core_tb;

  localparam int unsigned MaxV      = 512;
  localparam int          ItemGoal  = 1400;
  localparam int          QuietFrom = 1200;
  localparam int          HangLimit = 1500000;

  typedef struct packed {
    logic       mode;
    logic [9:0] a;
    logic [9:0] b;
  } cmd_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  logic       mode_i = ftc_pkg::ModeEdge;
  logic [9:0] vertex_a_i = '0;
  logic [9:0] vertex_b_i = '0;
  logic       result_valid_o;
  logic [9:0] tree_count_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i = '0;

  forest_tree_counter_core #(.MAX_VERTICES(MaxV)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cmd_t       pend_q[$];
  logic [9:0] count_q[$];
  int         gap_left = 0;
  bit         idle_en = 1'b1;
  int         errors = 0;
  int         sent = 0;
  int         evals_checked = 0;
  int         edges_taken = 0;
  int         quiet_cycles = 0;

  // predictor state
  bit [MaxV-1:0] adj_m [MaxV];
  bit [MaxV-1:0] seen_m;
  logic [9:0]    vcount_m = 10'd1;

  function automatic logic [9:0] count_trees();
    int n, sp, v, i;
    int unsigned trees;
    bit cyc;
    int stk_v [MaxV];
    int stk_n [MaxV];
    n = (vcount_m > MaxV) ? MaxV : int'(vcount_m);
    trees = 0;
    for (int s = 0; s < n; s++) begin
      if (seen_m[s]) continue;
      cyc = 1'b0;
      seen_m[s] = 1'b1;
      stk_v[0] = s;
      stk_n[0] = 0;
      sp = 1;
      while (sp > 0) begin
        v = stk_v[sp-1];
        i = stk_n[sp-1];
        if (i >= n) begin
          sp--;
          continue;
        end
        stk_n[sp-1] = i + 1;
        if (!adj_m[v][i]) continue;
        if (!seen_m[i]) begin
          // drop the tree edge so the way back is not taken as a cycle
          adj_m[v][i] = 1'b0;
          adj_m[i][v] = 1'b0;
          seen_m[i] = 1'b1;
          if (sp < MaxV) begin
            stk_v[sp] = i;
            stk_n[sp] = 0;
            sp++;
          end
        end else begin
          cyc = 1'b1;
        end
      end
      if (!cyc && trees < ftc_pkg::CountMax) trees++;
    end
    return trees[9:0];
  endfunction

  // driver
  always @(posedge clk_i) begin
    cmd_t c;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
        c = pend_q.pop_front();
        mode_i <= c.mode;
        vertex_a_i <= c.a;
        vertex_b_i <= c.b;
        start_i <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 7);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    logic [9:0] want;
    logic [$clog2(MaxV)-1:0] ra, rb;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_m = cfg_data_i;
        moved = 1'b1;
      end
      if (start_i && !busy_o) begin
        moved = 1'b1;
        if (mode_i == ftc_pkg::ModeEdge) begin
          edges_taken++;
          if (vertex_a_i >= 1 && vertex_a_i <= MaxV &&
              vertex_b_i >= 1 && vertex_b_i <= MaxV) begin
            ra = $clog2(MaxV)'(vertex_a_i - 10'd1);
            rb = $clog2(MaxV)'(vertex_b_i - 10'd1);
            adj_m[ra][rb] = 1'b1;
            adj_m[rb][ra] = 1'b1;
          end
        end else begin
          count_q.push_back(count_trees());
          for (int r = 0; r < MaxV; r++) adj_m[r] = '0;
          seen_m = '0;
        end
      end
      if (result_valid_o) begin
        moved = 1'b1;
        if (count_q.size() == 0) begin
          $error("tree_count: unexpected result %0d", tree_count_o);
          errors++;
        end else begin
          want = count_q.pop_front();
          evals_checked++;
          if (tree_count_o !== want) begin
            $error("tree_count: expected %0d, actual %0d", want, tree_count_o);
            errors++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
        $display("watchdog: no transfer for %0d cycles", HangLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_cmd(logic mode, logic [9:0] a, logic [9:0] b);
    cmd_t c;
    c.mode = mode;
    c.a = a;
    c.b = b;
    pend_q.push_back(c);
    sent++;
  endtask

  // hold until everything is drained, then let the clearing pass finish
  task automatic drain();
    while (pend_q.size() > 0 || start_i || count_q.size() > 0) @(posedge clk_i);
    repeat (MaxV + 64) @(posedge clk_i);
  endtask

  task automatic write_vcount(logic [9:0] n);
    drain();
    cfg_data_i <= n;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int n, k;
    logic [9:0] a, b;
    for (int r = 0; r < MaxV; r++) adj_m[r] = '0;
    seen_m = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset value of one vertex: a lone vertex is one tree
    push_cmd(ftc_pkg::ModeEval, 10'h3FF, 10'h000);
    write_vcount(10'd0);
    push_cmd(ftc_pkg::ModeEval, 10'd0, 10'd1023);
    write_vcount(10'd4);
    push_cmd(ftc_pkg::ModeEdge, 10'd1, 10'd1);      // self loop
    push_cmd(ftc_pkg::ModeEdge, 10'd2, 10'd3);
    push_cmd(ftc_pkg::ModeEdge, 10'd3, 10'd2);      // repeat collapses
    push_cmd(ftc_pkg::ModeEdge, 10'd0, 10'd2);      // ignored endpoint
    push_cmd(ftc_pkg::ModeEdge, 10'd600, 10'd3);
    push_cmd(ftc_pkg::ModeEdge, 10'd1023, 10'd1023);
    push_cmd(ftc_pkg::ModeEdge, 10'd4, 10'd9);      // beyond vertex count
    push_cmd(ftc_pkg::ModeEval, 10'd0, 10'd0);
    write_vcount(10'd3);
    push_cmd(ftc_pkg::ModeEdge, 10'd1, 10'd2);
    push_cmd(ftc_pkg::ModeEdge, 10'd2, 10'd3);
    push_cmd(ftc_pkg::ModeEdge, 10'd3, 10'd1);
    push_cmd(ftc_pkg::ModeEval, 10'd0, 10'd0);
    write_vcount(10'd512);
    push_cmd(ftc_pkg::ModeEdge, 10'd512, 10'd1);
    push_cmd(ftc_pkg::ModeEdge, 10'd511, 10'd512);
    push_cmd(ftc_pkg::ModeEdge, 10'd256, 10'd256);
    push_cmd(ftc_pkg::ModeEval, 10'd0, 10'd0);
    write_vcount(10'd1023);
    push_cmd(ftc_pkg::ModeEdge, 10'd513, 10'd1);
    push_cmd(ftc_pkg::ModeEdge, 10'd100, 10'd200);
    push_cmd(ftc_pkg::ModeEval, 10'd0, 10'd0);

    // random graphs, mostly small and well formed
    while (sent < ItemGoal) begin
      if (sent >= QuietFrom) idle_en = 1'b0;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 24);
      write_vcount(n[9:0]);
      k = $urandom_range(0, 2 * n + 2);
      for (int e = 0; e < k; e++) begin
        if (n > 0 && $urandom_range(0, 9) != 0) begin
          a = 10'($urandom_range(1, n));
          b = 10'($urandom_range(1, n));
        end else begin
          a = 10'($urandom_range(0, 1023));
          b = 10'($urandom_range(0, 1023));
        end
        // an occasional early evaluate splits the graph
        push_cmd(($urandom_range(0, 29) == 0) ? ftc_pkg::ModeEval : ftc_pkg::ModeEdge, a, b);
      end
      push_cmd(ftc_pkg::ModeEval, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end

    drain();
    $display("covered %0d commands: %0d edge transfers, %0d tree counts checked",
             sent, edges_taken, evals_checked);
    $display("vertex counts from 0 to 1023, self loops, repeats and ignored endpoints");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ftc_pkg.sv
hdl/ftc_ram.sv
hdl/forest_tree_counter_core.sv
test/forest_tree_counter_core_tb.sv
